@@ rtl/core/button_short_long_press_debounce_top_defines.svh @@
// Assertion macros shared by the button press classifier RTL.
`ifndef BUTTON_SHORT_LONG_PRESS_DEBOUNCE_TOP_DEFINES_SVH
`define BUTTON_SHORT_LONG_PRESS_DEBOUNCE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define BSLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define BSLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BSLP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSLP_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/bslp_pkg.sv @@
package bslp_pkg;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_TAKE   = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    // Configuration register indexes
    localparam logic CFG_DEBOUNCE   = 1'b0;
    localparam logic CFG_LONG_PRESS = 1'b1;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1500;

    // One button's state word; level doubles as the previous sampled level.
    typedef struct packed
    {
        logic        level;
        logic [31:0] press_stamp;
        logic [31:0] release_stamp;
        logic        long_reported;
        event_t      pending;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ rtl/core/bslp_ram.sv @@
module bslp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/bslp_update.sv @@
module bslp_update (
    input  bslp_pkg::entry_t  cur,
    input  bslp_pkg::opcode_t op,
    input  logic              pressed,
    input  logic [31:0]       now_ms,
    input  logic [15:0]       deb_limit,
    input  logic [15:0]       long_limit,
    output bslp_pkg::entry_t  nxt,
    output bslp_pkg::event_t  press_event,
    output logic              held
);

    import bslp_pkg::*;

    logic [31:0] since_release;
    logic [31:0] since_press;
    logic        rel_ok;
    logic        hold_ok;
    logic        hold_long;

    assign since_release = now_ms - cur.release_stamp;
    assign since_press   = now_ms - cur.press_stamp;
    assign rel_ok        = since_release >= {16'd0, deb_limit};
    assign hold_ok       = since_press >= {16'd0, deb_limit};
    assign hold_long     = since_press >= {16'd0, long_limit};

    always_comb
    begin
        nxt         = cur;
        press_event = cur.pending;
        held        = cur.level;
        if (op == OP_SAMPLE)
        begin
            nxt.level = pressed;
            if (pressed && !cur.level)
            begin
                // Start a new hold unless the press bounced off the release
                if (rel_ok)
                begin
                    nxt.press_stamp   = now_ms;
                    nxt.long_reported = 1'b0;
                end
            end
            else if (!pressed && cur.level)
            begin
                if (hold_ok)
                begin
                    nxt.release_stamp = now_ms;
                    if (!hold_long && !cur.long_reported)
                    begin
                        nxt.pending = EV_SHORT;
                    end
                end
            end
            else if (pressed && cur.level)
            begin
                if (!cur.long_reported && hold_long)
                begin
                    nxt.pending       = EV_LONG;
                    nxt.long_reported = 1'b1;
                end
            end
            press_event = nxt.pending;
            held        = pressed;
        end
        else
        begin
            // Take the pending event and clear it
            nxt.pending = EV_NONE;
        end
    end

endmodule

@@ rtl/core/button_short_long_press_debounce_top.sv @@
// Channel  | Handshake               | Payload
// ---------+-------------------------+-----------------------------------------
// input    | in_valid / in_ready     | opcode, button_index, pressed, now_ms
// result   | out_valid / out_ready   | press_event, held
// config   | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready holds; each result reaches
// the output register via the update stage (the transfer edge launches
// the state RAM read, the update runs while the item sits in that stage).
// The registered read of the per-button state RAM sets the latency; the
// last write is forwarded so back-to-back items on the same button see
// fresh state.
// Reset clears the per-entry valid bits at once: an unwritten entry reads
// as all zero, so no clearing pass is needed.
// A stalled result holds the update stage; input is taken while the output
// register drains in the same cycle.

`include "button_short_long_press_debounce_top_defines.svh"

module button_short_long_press_debounce_top #(
    parameter int NUM_BUTTONS = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    input  logic              button_index,
    input  logic              pressed,
    input  logic [31:0]       now_ms,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        press_event,
    output logic              held,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [15:0]       cfg_wdata
);

    import bslp_pkg::*;

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Configuration registers
    logic [15:0] debounce_reg;
    logic [15:0] long_press_reg;

    // Update stage
    logic          s1_valid_reg;
    opcode_t       s1_op_reg;
    logic          s1_pressed_reg;
    logic [31:0]   s1_now_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_inrange_reg;

    // Forwarding of the most recent RAM write
    logic          wb_valid_reg;
    logic [AW-1:0] wb_addr_reg;
    entry_t        wb_data_reg;

    logic [NUM_BUTTONS-1:0] entry_valid_reg;

    // Output register
    logic        out_valid_reg;
    event_t      ev_out_reg;
    logic        held_out_reg;

    logic               in_xfer;
    logic               s1_go;
    logic [AW-1:0]      in_addr;
    logic               in_range;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    logic               entry_known;
    entry_t             cur_entry;
    entry_t             nxt_entry;
    event_t             upd_event;
    logic               upd_held;

    assign in_addr  = AW'(button_index);
    assign in_range = (int'(button_index) < NUM_BUTTONS);

    // Advance the update stage when the output register is empty or drains
    assign s1_go    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_xfer  = in_valid && in_ready;
    assign ram_we   = s1_go && s1_inrange_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DEBOUNCE)
            begin
                debounce_reg <= cfg_wdata;
            end
            else
            begin
                long_press_reg <= cfg_wdata;
            end
        end
    end

    bslp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUTTONS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (nxt_entry),
        .re    (in_xfer),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Pick the freshest copy: last write, then RAM, then reset value
    always_comb
    begin
        entry_known = 1'b0;
        if (s1_inrange_reg)
        begin
            entry_known = entry_valid_reg[s1_addr_reg];
        end
        if (wb_valid_reg && (wb_addr_reg == s1_addr_reg))
        begin
            cur_entry = wb_data_reg;
        end
        else if (entry_known)
        begin
            cur_entry = entry_t'(ram_rdata);
        end
        else
        begin
            cur_entry = '0;
        end
    end

    bslp_update u_update (
        .cur         (cur_entry),
        .op          (s1_op_reg),
        .pressed     (s1_pressed_reg),
        .now_ms      (s1_now_reg),
        .deb_limit   (debounce_reg),
        .long_limit  (long_press_reg),
        .nxt         (nxt_entry),
        .press_event (upd_event),
        .held        (upd_held)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            wb_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                wb_valid_reg                 <= 1'b1;
                entry_valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg      <= opcode_t'(opcode);
            s1_pressed_reg <= pressed;
            s1_now_reg     <= now_ms;
            s1_addr_reg    <= in_addr;
            s1_inrange_reg <= in_range;
        end
        if (ram_we)
        begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= nxt_entry;
        end
        if (s1_go)
        begin
            // Drop the update for a button that does not exist
            ev_out_reg   <= s1_inrange_reg ? upd_event : EV_NONE;
            held_out_reg <= s1_inrange_reg && upd_held;
        end
    end

    assign out_valid   = out_valid_reg;
    assign press_event = ev_out_reg;
    assign held        = held_out_reg;

    `BSLP_ASSERT_IMP(a_no_bad_event, clk, rst_n, ram_we, nxt_entry.pending != 2'd3)
    `BSLP_ASSERT_IMP(a_take_clears, clk, rst_n, ram_we && (s1_op_reg == OP_TAKE),
        nxt_entry.pending == EV_NONE)
    `BSLP_ASSERT_NXT(a_fwd_tracks_write, clk, rst_n, ram_we,
        wb_valid_reg && (wb_addr_reg == $past(s1_addr_reg)))
    `BSLP_ASSERT_NXT(a_xfer_fills_stage, clk, rst_n, in_xfer, s1_valid_reg)
    `BSLP_ASSERT_NXT(a_advance_fills_out, clk, rst_n, s1_go, out_valid_reg)

endmodule
